### sv/gohp_pkg.sv
package gohp_pkg;

  localparam int PIX_W = 8;
  localparam int BIN_W = 6;
  localparam int WEIGHT_W = 24;
  localparam int ANG_W = 32;
  localparam int TABLE_LEN = 24;
  // 1/K in Q16
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

  // vector components: |dx| * 256 grows by the gain 1.65 and the root of 2
  localparam int VEC_W = 21;

  typedef struct packed {
    logic signed [PIX_W:0] dx;
    logic signed [PIX_W:0] dy;
    logic                  take;
    logic                  last;
  } gohp_cmd_t;

  typedef struct packed {
    logic [BIN_W-1:0]    bin;
    logic [WEIGHT_W-1:0] weight;
  } gohp_res_t;

  function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    v = '0;
    unique case (i)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/gohp_if.sv
interface gohp_if #(
  parameter int W = 1
) (
  input logic clk
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/gohp_front.sv
module gohp_front #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [gohp_pkg::PIX_W-1:0] left_pixel,
  input  logic [gohp_pkg::PIX_W-1:0] right_pixel,
  input  logic [gohp_pkg::PIX_W-1:0] upper_pixel,
  input  logic [gohp_pkg::PIX_W-1:0] lower_pixel,
  input  logic                   last_sample,
  output logic                   q_valid,
  input  logic                   q_ready,
  output gohp_pkg::gohp_cmd_t    q_cmd
);
  import gohp_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int DEPTH = 2;

  gohp_cmd_t        fifo_r [DEPTH];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic [CNT_W-1:0] samp_r;
  gohp_cmd_t        cmd;
  logic             push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = fifo_r[rp_r];

  always_comb begin
    cmd.dx = $signed({1'b0, right_pixel}) - $signed({1'b0, left_pixel});
    cmd.dy = $signed({1'b0, lower_pixel}) - $signed({1'b0, upper_pixel});
    cmd.take = (samp_r < CNT_W'(MAX_SAMPLES));
    cmd.last = last_sample;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
      samp_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
        // count samples per keypoint, restart after last
        if (last_sample) begin
          samp_r <= '0;
        end else if (cmd.take) begin
          samp_r <= samp_r + 1'b1;
        end
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### sv/gohp_back.sv
module gohp_back #(
  parameter int NUM_BINS = 36,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  gohp_pkg::gohp_cmd_t q_cmd,
  output logic                r_valid,
  input  logic                r_ready,
  output gohp_pkg::gohp_res_t r_res
);
  import gohp_pkg::*;

  localparam int BI_W = $clog2(NUM_BINS);
  localparam int ST_W = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ITER, S_MAG, S_READ, S_ADD, S_SCAN, S_PICK, S_CLEAR, S_OUT
  } state_t;

  state_t                      state_r;
  logic signed [VEC_W-1:0]     x_r, y_r;
  logic [ANG_W-1:0]            ang_r;
  logic [ST_W-1:0]             step_r;
  logic                        last_r, take_r;
  logic [WEIGHT_W-1:0]         hist_r [NUM_BINS];
  logic [WEIGHT_W-1:0]         rd_r;
  logic [BI_W-1:0]             rd_addr;
  logic [BI_W-1:0]             bin_r, idx_r, best_r;
  logic [WEIGHT_W-1:0]         mag_r, bestw_r;
  logic [VEC_W+15:0]           prod;
  logic [ANG_W+BI_W:0]         bprod;
  logic [BI_W:0]               braw;
  logic [WEIGHT_W:0]           sum;
  logic signed [VEC_W-1:0]     xs, ys, x0, y0;

  assign q_ready = (state_r == S_IDLE);
  assign r_valid = (state_r == S_OUT);
  assign r_res.bin = BIN_W'(best_r);
  assign r_res.weight = bestw_r;
  assign rd_addr = (state_r == S_SCAN) ? idx_r : bin_r;

  always_comb begin
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    x0 = VEC_W'($signed(q_cmd.dx)) <<< 8;
    y0 = VEC_W'($signed(q_cmd.dy)) <<< 8;
    prod = (VEC_W+16)'(x_r[VEC_W-1] ? '0 : x_r) * (VEC_W+16)'(INV_GAIN_Q16)
           + (VEC_W+16)'(20'h80000);
    bprod = (ANG_W+BI_W+1)'(ang_r) * (ANG_W+BI_W+1)'(NUM_BINS)
            + (ANG_W+BI_W+1)'(33'h080000000);
    braw = bprod[ANG_W +: BI_W+1];
    sum = {1'b0, rd_r} + {1'b0, mag_r};
  end

  always_ff @(posedge clk) begin
    rd_r <= hist_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r <= '0;
      last_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            last_r <= q_cmd.last;
            take_r <= q_cmd.take;
            step_r <= '0;
            if (q_cmd.dx[PIX_W]) begin
              x_r <= -x0;
              y_r <= -y0;
              ang_r <= 32'h80000000;
            end else begin
              x_r <= x0;
              y_r <= y0;
              ang_r <= '0;
            end
            state_r <= q_cmd.take ? S_ITER : S_ADD;
          end
        end
        S_ITER: begin
          if (!y_r[VEC_W-1]) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            ang_r <= ang_r + atan_turn(5'(step_r));
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            ang_r <= ang_r - atan_turn(5'(step_r));
          end
          step_r <= step_r + 1'b1;
          if (step_r == ST_W'(CORDIC_STEPS - 1)) begin
            state_r <= S_MAG;
          end
        end
        S_MAG: begin
          mag_r <= WEIGHT_W'(prod >> 20);
          bin_r <= (braw >= (BI_W+1)'(NUM_BINS)) ? '0 : BI_W'(braw);
          state_r <= S_READ;
        end
        S_READ: begin
          // wait state for the registered bin read
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (take_r) begin
            hist_r[bin_r] <= sum[WEIGHT_W] ? WEIGHT_MAX : sum[WEIGHT_W-1:0];
          end
          if (last_r) begin
            best_r <= '0;
            bestw_r <= '0;
            idx_r <= '0;
            state_r <= S_SCAN;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SCAN: begin
          // read data belongs to the previous index; strict compare keeps the first maximum
          if (idx_r != '0 && rd_r > bestw_r) begin
            best_r <= idx_r - 1'b1;
            bestw_r <= rd_r;
          end
          if (idx_r == BI_W'(NUM_BINS - 1)) begin
            idx_r <= '0;
            state_r <= S_PICK;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_PICK: begin
          if (rd_r > bestw_r) begin
            best_r <= BI_W'(NUM_BINS - 1);
            bestw_r <= rd_r;
          end
          state_r <= S_CLEAR;
        end
        S_CLEAR: begin
          hist_r[idx_r] <= '0;
          if (idx_r == BI_W'(NUM_BINS - 1)) begin
            idx_r <= '0;
            state_r <= last_r ? S_OUT : S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_OUT: begin
          if (r_ready) begin
            last_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    r_valid && !r_ready |=> r_valid && $stable(r_res))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !q_ready)
    else $error("queue popped while busy");
  a_bin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> bin_r < BI_W'(NUM_BINS))
    else $error("bin out of range");
`endif
endmodule

### sv/gradient_orientation_histogram_peak_unit.sv
// channel | dir | payload
// in      | in  | left/right/upper/lower_pixel, last_sample
// out     | out | dominant_bin, peak_weight
// A pixel runs CORDIC_STEPS turns of the shared CORDIC loop in the back part, then
// the magnitude and bin step, the bin read and the add; a pixel past MAX_SAMPLES
// goes straight to the add. A last pixel adds the peak scan and clear sweep, then
// the result hand-over. After reset all bins are cleared before the first pixel.
// A two-entry queue lets input transfers continue while the back part is busy.
// The result holds until its transfer.
module gradient_orientation_histogram_peak_unit #(
  parameter int NUM_BINS = 36,
  parameter int MAX_SAMPLES = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  gohp_if.sink   in_ch,
  gohp_if.source out_ch
);
  import gohp_pkg::*;

  logic      q_valid, q_ready, r_valid;
  gohp_cmd_t q_cmd;
  gohp_res_t r_res;

  gohp_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .left_pixel(in_ch.data[7:0]), .right_pixel(in_ch.data[15:8]),
    .upper_pixel(in_ch.data[23:16]), .lower_pixel(in_ch.data[31:24]),
    .last_sample(in_ch.data[32]),
    .q_valid, .q_ready, .q_cmd
  );

  gohp_back #(.NUM_BINS(NUM_BINS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .r_valid, .r_ready(out_ch.ready), .r_res
  );

  assign out_ch.valid = r_valid;
  assign out_ch.data = {r_res.weight, r_res.bin};
endmodule
